// ===== rtl/mpfl_pkg.sv =====
// ----------------------------------------------------------------------------
// Multi-pool free-list allocator package
// Shared types, codes and default sizes for the allocator and its parts.
// ----------------------------------------------------------------------------
package mpfl_pkg;

   // Default sizes, used as parameter defaults on the top level.
   localparam int DEF_NUM_ENTITIES = 256;
   localparam int DEF_NUM_POOLS    = 4;

   // Request operations.
   typedef enum logic [1:0] {
      OP_CLAIM   = 2'd0,
      OP_RELEASE = 2'd1,
      OP_CREATE  = 2'd2,
      OP_BIND    = 2'd3
   } op_type;

   // Result status codes.
   typedef enum logic [2:0] {
      ST_OK           = 3'd0,
      ST_NO_POOL      = 3'd1,
      ST_EXHAUSTED    = 3'd2,
      ST_UNBOUND      = 3'd3,
      ST_ALREADY_FREE = 3'd4
   } status_type;

   // Controller states.
   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_LOOKUP,
      S_LINK,
      S_SWEEP
   } state_type;

   // One request item.
   typedef struct packed {
      op_type       opcode;
      logic [1:0]   pool_index;
      logic [7:0]   entity_id;
      logic [8:0]   capacity;
   } req_type;

   // One result item.
   typedef struct packed {
      logic [7:0]   claimed_entity;
      status_type   status;
      logic [8:0]   free_num;
      logic [8:0]   used_num;
   } rsp_type;

endpackage

// ===== rtl/multi_pool_free_list_allocator.sv =====
// ----------------------------------------------------------------------------
// Multi-pool free-list allocator
// Keeps several object pools, each a LIFO free list linked through a
// per-entity table, and serves claim, release, create and bind requests.
// ----------------------------------------------------------------------------
// Usage:
// Requests enter on req_valid/req_data and are taken when req_stall is low.
// Each request yields exactly one result on rsp_valid/rsp_data, held until
// the receiver drops rsp_stall.
// Claim and release pass through S_IDLE, S_LOOKUP and S_LINK: the pool
// entry and the entity entry are read from single-ported-read RAMs one
// after the other (claim needs the head before it can read the head's
// link; release needs the entity's pool before it can read that pool).
// Create, bind and requests that fail early pass through S_IDLE and
// S_LOOKUP only. The result appears in the cycle after the last state.
// Re-creating a pool that exists walks the entity table once, one entry per
// cycle, before the next item is taken.
// After reset both tables are cleared, one entry per cycle, over
// max(NUM_ENTITIES, NUM_POOLS) entries; req_stall stays high meanwhile.
// A stalled result stays in the output register; the core takes the next
// item, reads its table entries and then waits, before any table write,
// until the register is free. req_stall stays high meanwhile.
// ----------------------------------------------------------------------------
module multi_pool_free_list_allocator import mpfl_pkg::*; #(
   parameter int NUM_ENTITIES = DEF_NUM_ENTITIES,
   parameter int NUM_POOLS    = DEF_NUM_POOLS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic    core_idle, out_free, res_valid;
   rsp_type res_data;
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   mpfl_core #(.NUM_ENTITIES(NUM_ENTITIES), .NUM_POOLS(NUM_POOLS)) u_core (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_data (req_data),
      .idle     (core_idle),
      .out_free (out_free),
      .res_valid(res_valid),
      .res_data (res_data)
   );

   assign req_stall = !core_idle;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp_data_ff <= res_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The core only hands over a result when the output register can take it.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result produced while output register is occupied");

   // Only a successful claim names an entity.
   a_entity_only_on_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != ST_OK) |-> (rsp_data.claimed_entity == '0))
      else $error("entity reported on a failed request");

   // A missing pool reports zero counts.
   a_no_pool_counts: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ST_NO_POOL)
         |-> (rsp_data.free_num == '0 && rsp_data.used_num == '0))
      else $error("counts reported for a missing pool");

   // No request is taken while the core works on an item.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second item taken while the first is in flight");

endmodule

// ===== rtl/mpfl_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered, held while the
// read enable is low.
// ----------------------------------------------------------------------------
module mpfl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/mpfl_core.sv =====
// ----------------------------------------------------------------------------
// Allocator core
// Entity and pool tables in two RAMs, and the sequencer that reads, updates
// and writes them back for each item, including the reset clearing pass and
// the sweep that drops the free list of a re-created pool.
// ----------------------------------------------------------------------------
module mpfl_core import mpfl_pkg::*; #(
   parameter int NUM_ENTITIES = DEF_NUM_ENTITIES,
   parameter int NUM_POOLS    = DEF_NUM_POOLS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  req_type req_data,
   output logic    idle,
   input  logic    out_free,
   output logic    res_valid,
   output rsp_type res_data
);

   localparam int ENT_AW  = $clog2(NUM_ENTITIES);
   localparam int LINK_W  = $clog2(NUM_ENTITIES) + 1;
   localparam int POOL_AW = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
   localparam int CNT_W   = $clog2(NUM_ENTITIES + 1);
   localparam int CLR_N   = (NUM_ENTITIES > NUM_POOLS) ? NUM_ENTITIES : NUM_POOLS;
   localparam int SWP_W   = $clog2(CLR_N + 1);

   localparam logic [LINK_W-1:0] NIL     = LINK_W'(NUM_ENTITIES);
   localparam logic [CNT_W-1:0]  CNT_MAX = CNT_W'(NUM_ENTITIES);

   typedef struct packed {
      logic [LINK_W-1:0]  link;
      logic [POOL_AW-1:0] pool;
      logic               bound;
      logic               free;
   } ent_type;

   typedef struct packed {
      logic [LINK_W-1:0] head;
      logic [CNT_W-1:0]  free_cnt;
      logic [CNT_W-1:0]  used_cnt;
      logic              exists;
   } pool_type;

   localparam ent_type  ENT_RESET  = '{link: NIL, pool: '0, bound: 1'b0, free: 1'b0};
   localparam pool_type POOL_RESET = '{head: NIL, free_cnt: '0, used_cnt: '0,
                                       exists: 1'b0};

   // Saturating counters.
   function automatic logic [CNT_W-1:0] cnt_up(input logic [CNT_W-1:0] c);
      return (c >= CNT_MAX) ? CNT_MAX : c + 1'b1;
   endfunction

   function automatic logic [CNT_W-1:0] cnt_down(input logic [CNT_W-1:0] c);
      return (c == '0) ? '0 : c - 1'b1;
   endfunction

   state_type          state_ff, state_in;
   req_type            item_ff, item_in;
   logic [SWP_W-1:0]   cnt_ff, cnt_in;
   logic               pend_ff, pend_in;
   logic [ENT_AW-1:0]  pend_addr_ff, pend_addr_in;

   logic               ent_we, ent_re, pool_we, pool_re;
   logic [ENT_AW-1:0]  ent_waddr, ent_raddr;
   logic [POOL_AW-1:0] pool_waddr, pool_raddr;
   ent_type            ent_wdata, ent_q;
   pool_type           pool_wdata, pool_q;

   logic               pool_ok, id_ok, pool_in_range;
   logic [ENT_AW-1:0]  id_addr;
   logic [POOL_AW-1:0] p_addr;
   logic [CNT_W-1:0]   cap_clamped;

   // Entity table: link, owning pool, bound and free marks.
   mpfl_ram #(.WIDTH($bits(ent_type)), .DEPTH(NUM_ENTITIES)) u_ent_ram (
      .clock  (clock),
      .wr_en  (ent_we),
      .wr_addr(ent_waddr),
      .wr_data(ent_wdata),
      .rd_en  (ent_re),
      .rd_addr(ent_raddr),
      .rd_data(ent_q)
   );

   // Pool table: list head, counts and existence.
   mpfl_ram #(.WIDTH($bits(pool_type)), .DEPTH(NUM_POOLS)) u_pool_ram (
      .clock  (clock),
      .wr_en  (pool_we),
      .wr_addr(pool_waddr),
      .wr_data(pool_wdata),
      .rd_en  (pool_re),
      .rd_addr(pool_raddr),
      .rd_data(pool_q)
   );

   // Decoded fields of the item in flight.
   assign pool_in_range = int'(item_ff.pool_index) < NUM_POOLS;
   assign pool_ok       = pool_in_range && pool_q.exists;
   assign id_ok         = int'(item_ff.entity_id) < NUM_ENTITIES;
   assign id_addr       = ENT_AW'(item_ff.entity_id);
   assign p_addr        = POOL_AW'(item_ff.pool_index);
   assign cap_clamped   = (int'(item_ff.capacity) > NUM_ENTITIES) ? CNT_MAX
                                                                  : CNT_W'(item_ff.capacity);
   assign idle          = (state_ff == S_IDLE);

   // State and item registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         cnt_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      pend_addr_ff <= pend_addr_in;
   end

   // Sequencer: next state, table accesses and the result.
   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      cnt_in       = cnt_ff;
      pend_in      = 1'b0;
      pend_addr_in = pend_addr_ff;
      ent_re       = 1'b0;
      ent_raddr    = id_addr;
      pool_re      = 1'b0;
      pool_raddr   = p_addr;
      ent_we       = 1'b0;
      ent_waddr    = id_addr;
      ent_wdata    = ent_q;
      pool_we      = 1'b0;
      pool_waddr   = p_addr;
      pool_wdata   = pool_q;
      res_valid    = 1'b0;
      res_data.claimed_entity = '0;
      res_data.status         = ST_OK;
      res_data.free_num       = '0;
      res_data.used_num       = '0;

      unique case (state_ff)
         S_CLEAR: begin
            // Reset pass: one entry of each table per cycle.
            ent_we     = int'(cnt_ff) < NUM_ENTITIES;
            ent_waddr  = ENT_AW'(cnt_ff);
            ent_wdata  = ENT_RESET;
            pool_we    = int'(cnt_ff) < NUM_POOLS;
            pool_waddr = POOL_AW'(cnt_ff);
            pool_wdata = POOL_RESET;
            cnt_in     = cnt_ff + 1'b1;
            if (int'(cnt_ff) == CLR_N - 1) begin
               state_in = S_IDLE;
               cnt_in   = '0;
            end
         end

         S_IDLE: begin
            // Take an item and fetch its entity and pool entries.
            if (req_valid) begin
               item_in    = req_data;
               ent_re     = 1'b1;
               ent_raddr  = ENT_AW'(req_data.entity_id);
               pool_re    = 1'b1;
               pool_raddr = POOL_AW'(req_data.pool_index);
               state_in   = S_LOOKUP;
            end
         end

         S_LOOKUP: begin
            if (out_free) begin
               unique case (item_ff.opcode)
                  OP_CLAIM: begin
                     if (!pool_ok) begin
                        res_valid       = 1'b1;
                        res_data.status = ST_NO_POOL;
                        state_in        = S_IDLE;
                     end else if (pool_q.head == NIL) begin
                        res_valid         = 1'b1;
                        res_data.status   = ST_EXHAUSTED;
                        res_data.free_num = 9'(pool_q.free_cnt);
                        res_data.used_num = 9'(pool_q.used_cnt);
                        state_in          = S_IDLE;
                     end else begin
                        // Fetch the head entity to learn its successor.
                        ent_re    = 1'b1;
                        ent_raddr = ENT_AW'(pool_q.head);
                        state_in  = S_LINK;
                     end
                  end

                  OP_RELEASE: begin
                     if (!id_ok || !ent_q.bound) begin
                        res_valid       = 1'b1;
                        res_data.status = ST_UNBOUND;
                        state_in        = S_IDLE;
                     end else begin
                        // Fetch the pool the entity belongs to.
                        pool_re    = 1'b1;
                        pool_raddr = ent_q.pool;
                        state_in   = S_LINK;
                     end
                  end

                  OP_CREATE: begin
                     res_valid = 1'b1;
                     state_in  = S_IDLE;
                     if (!pool_in_range) begin
                        res_data.status = ST_NO_POOL;
                     end else begin
                        pool_we             = 1'b1;
                        pool_wdata.head     = NIL;
                        pool_wdata.free_cnt = '0;
                        pool_wdata.used_cnt = cap_clamped;
                        pool_wdata.exists   = 1'b1;
                        res_data.used_num   = 9'(cap_clamped);
                        // An existing pool loses its old free list.
                        if (pool_q.exists) begin
                           state_in = S_SWEEP;
                           cnt_in   = '0;
                        end
                     end
                  end

                  OP_BIND: begin
                     res_valid = 1'b1;
                     state_in  = S_IDLE;
                     if (!pool_ok) begin
                        res_data.status = ST_NO_POOL;
                     end else begin
                        res_data.free_num = 9'(pool_q.free_cnt);
                        res_data.used_num = 9'(pool_q.used_cnt);
                        if (!id_ok) begin
                           res_data.status = ST_UNBOUND;
                        end else if (ent_q.free) begin
                           res_data.status = ST_ALREADY_FREE;
                        end else begin
                           ent_we          = 1'b1;
                           ent_wdata.link  = NIL;
                           ent_wdata.pool  = p_addr;
                           ent_wdata.bound = 1'b1;
                           ent_wdata.free  = 1'b0;
                        end
                     end
                  end

                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         S_LINK: begin
            if (out_free) begin
               res_valid = 1'b1;
               state_in  = S_IDLE;
               if (item_ff.opcode == OP_CLAIM) begin
                  // Pop: the head's successor becomes the new head.
                  ent_we                  = 1'b1;
                  ent_waddr               = ENT_AW'(pool_q.head);
                  ent_wdata.link          = NIL;
                  ent_wdata.free          = 1'b0;
                  pool_we                 = 1'b1;
                  pool_wdata.head         = ent_q.link;
                  pool_wdata.free_cnt     = cnt_down(pool_q.free_cnt);
                  pool_wdata.used_cnt     = cnt_up(pool_q.used_cnt);
                  res_data.claimed_entity = 8'(pool_q.head);
                  res_data.free_num       = 9'(cnt_down(pool_q.free_cnt));
                  res_data.used_num       = 9'(cnt_up(pool_q.used_cnt));
               end else if (!pool_q.exists) begin
                  res_data.status = ST_NO_POOL;
               end else if (ent_q.free) begin
                  res_data.status   = ST_ALREADY_FREE;
                  res_data.free_num = 9'(pool_q.free_cnt);
                  res_data.used_num = 9'(pool_q.used_cnt);
               end else begin
                  // Push the released entity in front of the old head.
                  ent_we              = 1'b1;
                  ent_wdata.link      = pool_q.head;
                  ent_wdata.free      = 1'b1;
                  pool_we             = 1'b1;
                  pool_waddr          = ent_q.pool;
                  pool_wdata.head     = LINK_W'(item_ff.entity_id);
                  pool_wdata.free_cnt = cnt_up(pool_q.free_cnt);
                  pool_wdata.used_cnt = cnt_down(pool_q.used_cnt);
                  res_data.free_num   = 9'(cnt_up(pool_q.free_cnt));
                  res_data.used_num   = 9'(cnt_down(pool_q.used_cnt));
               end
            end
         end

         S_SWEEP: begin
            // Read one entity per cycle, write back the one read before.
            if (int'(cnt_ff) < NUM_ENTITIES) begin
               ent_re       = 1'b1;
               ent_raddr    = ENT_AW'(cnt_ff);
               cnt_in       = cnt_ff + 1'b1;
               pend_in      = 1'b1;
               pend_addr_in = ENT_AW'(cnt_ff);
            end
            if (pend_ff && ent_q.bound && (ent_q.pool == p_addr)) begin
               ent_we         = 1'b1;
               ent_waddr      = pend_addr_ff;
               ent_wdata.link = NIL;
               ent_wdata.free = 1'b0;
            end
            if (int'(cnt_ff) == NUM_ENTITIES) begin
               state_in = S_IDLE;
               cnt_in   = '0;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule
